// ----- rtl/core/layered_bit_store_fnv_hash_core_macros.svh -----
// Assertion macros for the layered bit store core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LAYERED_BIT_STORE_FNV_HASH_CORE_MACROS_SVH
`define LAYERED_BIT_STORE_FNV_HASH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layered bit store assertion failed");
`define LBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layered bit store assertion failed");
`else
`define LBS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LBS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lbs_pkg.sv -----
// Shared types and constants for the layered bit store core.
// No dependencies; imported by the top level.
package lbs_pkg;

  localparam int DefLayers    = 8;
  localparam int DefLayerBits = 256;

  localparam int KindW  = 2;
  localparam int LayerW = 3;
  localparam int PosW   = 8;
  localparam int CountW = 9;
  localparam int FlipW  = 32;
  localparam int HashW  = 64;

  // Input tdata: layer, bit_pos, bit_value, padded to whole bytes.
  localparam int InFieldsW = LayerW + PosW + 1;
  localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
  // Output tdata: bit_out, layer_set_count, flip_total, store_hash.
  localparam int OutFieldsW = 1 + CountW + FlipW + HashW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [HashW-1:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

  typedef enum logic [KindW-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FLIP  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

endpackage

// ----- rtl/core/lbs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by the layered bit store core for the bit matrix.
module lbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/layered_bit_store_fnv_hash_core.sv -----
// Layered bit store: LAYERS rows of LAYER_BITS bits with a 64-bit FNV-1a store hash.
//
// Input stream (s_*): one transfer carries one operation. s_tuser is the kind
// (read, write, flip, clear all); s_tdata holds layer, bit_pos and bit_value.
// Output stream (m_*): exactly one transfer per operation, in order, carrying the
// addressed bit, the set-bit count of its row, the flip total and the store hash.
//
// The matrix lives in one RAM of LAYERS*LAYER_BITS/64 words with registered reads.
// Every change rereads the whole RAM and hashes one byte per cycle, so the hash
// pass sets the rate of writes, flips and clears; a read scans only the words of
// its addressed row, and an address out of range goes straight to the result.
//
// After reset a hash pass over the empty store runs with s_tready low; the RAM
// itself is never swept, per-word valid flags mark it empty.
// A finished result sits in an output register; the next operation is accepted
// while it waits, and its own result holds in the core until m_tready frees it.
`include "layered_bit_store_fnv_hash_core_macros.svh"
module layered_bit_store_fnv_hash_core #(
  parameter int LAYERS     = lbs_pkg::DefLayers,
  parameter int LAYER_BITS = lbs_pkg::DefLayerBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lbs_pkg::InDataW-1:0]  s_tdata,  // layer, bit_pos, bit_value
  input  logic [lbs_pkg::KindW-1:0]    s_tuser,  // kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lbs_pkg::OutDataW-1:0] m_tdata   // bit_out, layer_set_count, flip_total,
                                                 // store_hash
);
  import lbs_pkg::*;

  localparam int RowWords = LAYER_BITS / 64;
  localparam int NWords   = LAYERS * RowWords;
  localparam int AW       = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int RowW     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int ColW     = (RowWords > 1) ? $clog2(RowWords) : 1;
  localparam int CntW     = $clog2(RowWords * 64 + 1);
  localparam int PadW     = OutDataW - OutFieldsW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_HSTART,
    ST_HASH,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // x * 0x100000001B3 modulo 2^64, written as shifts and adds.
  function automatic logic [HashW-1:0] fnv_step(input logic [HashW-1:0] h,
                                                input logic [7:0] d);
    logic [HashW-1:0] x;
    x = h ^ {56'd0, d};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  state_t              state;
  logic                init;
  logic [NWords-1:0]   vld;
  logic [FlipW-1:0]    flips;
  logic [HashW-1:0]    hash;

  kind_t               it_kind;
  logic [LayerW-1:0]   it_layer;
  logic [PosW-1:0]     it_pos;
  logic                it_val;
  logic                cnt_en;
  logic [AW-1:0]       tgt_addr;

  logic [AW-1:0]       w;
  logic [RowW-1:0]     row;
  logic [ColW-1:0]     col;
  logic [2:0]          b_idx;
  logic                issued_all;
  logic [63:0]         word_q;

  logic                rd_pend;
  logic [AW-1:0]       rd_addr_q;
  logic [RowW-1:0]     rd_row_q;
  logic [ColW-1:0]     rd_col_q;

  logic                bit_q;
  logic [CntW-1:0]     cnt_q;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [63:0]         ram_wdata;
  logic [63:0]         ram_rdata;
  logic [RowW-1:0]     iss_row;
  logic [ColW-1:0]     iss_col;

  kind_t               in_kind;
  logic [LayerW-1:0]   in_layer;
  logic [PosW-1:0]     in_pos;
  logic                in_val;
  logic                in_range;
  logic                accept;

  logic [63:0]         eff;
  logic [63:0]         cur_word;
  logic [7:0]          cur_byte;
  logic [63:0]         bit_mask;
  logic [ColW-1:0]     col_adv;
  logic [RowW-1:0]     row_adv;
  logic                last_word;
  logic                proc;
  logic                row_hit;
  logic                hit;
  logic                clear_acc;
  logic                flip_src;

  assign in_kind  = kind_t'(s_tuser);
  assign in_layer = s_tdata[LayerW-1:0];
  assign in_pos   = s_tdata[LayerW+PosW-1:LayerW];
  assign in_val   = s_tdata[LayerW+PosW];
  assign in_range = (32'(in_layer) < LAYERS) && (32'(in_pos) < RowWords * 64);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Words never written since the last clear read as zero.
  assign eff      = vld[rd_addr_q] ? ram_rdata : 64'd0;
  assign cur_word = (b_idx == 3'd0) ? eff : word_q;
  assign cur_byte = cur_word[{b_idx, 3'b000} +: 8];
  assign bit_mask = 64'd1 << it_pos[5:0];

  assign col_adv   = (32'(col) == RowWords - 1) ? '0 : col + 1'b1;
  assign row_adv   = (32'(col) == RowWords - 1) ? row + 1'b1 : row;
  assign last_word = (32'(w) == NWords - 1);

  // Only words of the addressed row count toward its set-bit total.
  assign proc    = rd_pend && cnt_en && (state == ST_HASH || state == ST_SCAN);
  assign row_hit = (32'(rd_row_q) == 32'(it_layer));
  assign hit     = row_hit && (32'(rd_col_q) == 32'(it_pos[7:6]));

  assign clear_acc = accept && (in_kind == KIND_CLEAR);
  assign flip_src  = ((state == ST_RMW_WR) && (it_kind == KIND_FLIP)) || clear_acc;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = w;
    iss_row   = row;
    iss_col   = col;
    ram_we    = 1'b0;
    if (it_kind == KIND_WRITE) begin
      ram_wdata = it_val ? (eff | bit_mask) : (eff & ~bit_mask);
    end else begin
      ram_wdata = eff ^ bit_mask;
    end
    unique case (state)
      ST_RMW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_addr;
      end
      ST_RMW_WR: begin
        ram_we = 1'b1;
      end
      ST_HSTART: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        iss_row   = '0;
        iss_col   = '0;
      end
      ST_HASH: begin
        // Fetch the next word during the last byte of the current one.
        ram_re    = (b_idx == 3'd7) && !last_word;
        ram_raddr = w + 1'b1;
        iss_row   = row_adv;
        iss_col   = col_adv;
      end
      ST_SCAN: begin
        ram_re = !issued_all;
      end
      ST_IDLE, ST_FINISH: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  lbs_ram #(
    .WIDTH(64),
    .DEPTH(NWords)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tgt_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
    rd_row_q  <= iss_row;
    rd_col_q  <= iss_col;

    if (proc && row_hit) begin
      cnt_q <= cnt_q + CntW'($countones(eff));
      if (hit) begin
        bit_q <= eff[it_pos[5:0]];
      end
    end

    if (rst) begin
      state    <= ST_HSTART;
      init     <= 1'b1;
      vld      <= '0;
      flips    <= '0;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            it_kind  <= in_kind;
            it_layer <= in_layer;
            it_pos   <= in_pos;
            it_val   <= in_val;
            bit_q    <= 1'b0;
            cnt_q    <= '0;
            tgt_addr <= AW'(32'(in_layer) * RowWords + 32'(in_pos[7:6]));
            cnt_en   <= in_range && (in_kind != KIND_CLEAR);
            unique case (in_kind)
              KIND_CLEAR: begin
                vld   <= '0;
                flips <= '0;
                state <= ST_HSTART;
              end
              KIND_READ: begin
                w          <= AW'(32'(in_layer) * RowWords);
                row        <= RowW'(in_layer);
                col        <= '0;
                issued_all <= 1'b0;
                state      <= in_range ? ST_SCAN : ST_FINISH;
              end
              KIND_WRITE, KIND_FLIP: begin
                state <= in_range ? ST_RMW_RD : ST_FINISH;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_RMW_RD: begin
          state <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          vld[tgt_addr] <= 1'b1;
          if (it_kind == KIND_FLIP) begin
            flips <= flips + 1'b1;
          end
          state <= ST_HSTART;
        end
        ST_HSTART: begin
          w     <= '0;
          row   <= '0;
          col   <= '0;
          b_idx <= 3'd0;
          hash  <= FnvBasis;
          state <= ST_HASH;
        end
        ST_HASH: begin
          if (b_idx == 3'd0) begin
            word_q <= eff;
          end
          hash  <= fnv_step(hash, cur_byte);
          b_idx <= b_idx + 1'b1;
          if (b_idx == 3'd7) begin
            if (last_word) begin
              init  <= 1'b0;
              state <= init ? ST_IDLE : ST_FINISH;
            end else begin
              w   <= w + 1'b1;
              row <= row_adv;
              col <= col_adv;
            end
          end
        end
        ST_SCAN: begin
          if (!issued_all) begin
            w   <= w + 1'b1;
            col <= col_adv;
            if (32'(col) == RowWords - 1) begin
              issued_all <= 1'b1;
            end
          end
          if (rd_pend && 32'(rd_col_q) == RowWords - 1) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{PadW{1'b0}}, hash, flips, CountW'(cnt_q), bit_q};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Each word's data must be back from the RAM when its first byte is hashed.
  `LBS_ASSERT_IMP(a_hash_data, clk, rst, state == ST_HASH && b_idx == 3'd0, rd_pend)
  `LBS_ASSERT_NXT(a_clear_flips, clk, rst, clear_acc, flips == '0)
  `LBS_ASSERT_IMP(a_flip_src, clk, rst, !$past(rst) && flips != $past(flips), $past(flip_src))
  `LBS_ASSERT_IMP(a_out_src, clk, rst, !$past(rst) && $rose(m_tvalid), $past(state == ST_FINISH))

endmodule
